>>> hw/rtl/mso_pkg.sv
package mso_pkg;

    localparam int MARKER_LEN  = 5;
    localparam int KEY_BYTES   = 4;
    localparam int COUNT_WIDTH = 16;
    localparam int STR_W       = 16;
    localparam int FILL_W      = $clog2(MARKER_LEN + 1);
    localparam int PHASE_W     = $clog2(KEY_BYTES);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CARET_CHAR = 8'h5E;
    localparam logic [7:0] NUL_CHAR   = 8'h00;

    localparam logic [MARKER_LEN-1:0][7:0] MARKER_WORD =
        {8'h21, 8'h52, 8'h4F, 8'h58, 8'h21};

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [31:0] fresh_key;
        logic        stream_end;
    } t_in_item;

    typedef struct packed {
        logic [7:0]       out_byte;
        logic             out_end;
        logic [STR_W-1:0] strings_done;
    } t_out_item;

    typedef struct packed {
        logic [MARKER_LEN-1:0][7:0] bytes;
        logic [FILL_W-1:0]          count;
        logic                       last_end;
        logic [STR_W-1:0]           strings_done;
    } t_cmd;

endpackage

>>> hw/rtl/marker_string_xor_obfuscator_top.sv
// Byte stream obfuscator that rewrites each "!XOR!" marker into '^' and a key.
// The input channel (i_in_valid, o_in_ready, i_in_data) carries one byte per
// transfer together with a 32-bit key and an end-of-stream flag. The output
// channel (o_out_valid, i_out_ready, o_out_data) carries one result byte per
// transfer with its end flag and the running count of rewritten strings.
// The front keeps the five-byte window and the XOR state and turns each input
// into a group of zero to five result bytes; a two-entry queue holds these
// groups until the back sends them out, one byte per cycle while not stalled.
// Each group is registered in a queue entry and then in the back's r_cur.
// Throughput is one input byte per cycle while each input yields at most one
// result and the receiver is ready; a completed marker or an end-of-stream
// flush yields up to five results, and the back's byte rate sets it then.
// When the receiver stalls, the back holds its byte, the queue fills, and
// o_in_ready drops once both queue entries are taken.
// Reset empties the window and queue, leaves XOR mode and clears the count.
module marker_string_xor_obfuscator_top
    import mso_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    logic front_push;
    t_cmd front_cmd;
    logic q_valid;
    t_cmd q_cmd;
    logic q_pop;
    logic accept;

    assign accept = i_in_valid && o_in_ready;

    mso_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(accept),
        .i_item  (i_in_data),
        .o_push  (front_push),
        .o_cmd   (front_cmd)
    );

    mso_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_cmd   (front_cmd),
        .o_ready (o_in_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    mso_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_valid(q_valid),
        .i_q_cmd  (q_cmd),
        .o_pop    (q_pop),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_item   (o_out_data)
    );

endmodule

>>> hw/rtl/mso_front.sv
module mso_front
    import mso_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  t_in_item i_item,
    output logic     o_push,
    output t_cmd     o_cmd
);

    logic [MARKER_LEN-1:0][7:0] r_win;
    logic [MARKER_LEN-1:0][7:0] w_app;
    logic [FILL_W-1:0]          r_fill;
    logic [FILL_W-1:0]          new_fill;
    logic                       r_xor;
    logic [31:0]                r_key;
    logic [PHASE_W-1:0]         r_phase;
    logic [COUNT_WIDTH-1:0]     r_count;
    logic [COUNT_WIDTH-1:0]     n_count;
    logic [7:0]                 key_byte;
    logic                       win_full;
    logic                       match;

    always_comb begin
        for (int i = 0; i < MARKER_LEN; i++) begin
            w_app[i] = (r_fill == FILL_W'(i)) ? i_item.data_byte : r_win[i];
        end
    end

    assign new_fill = r_fill + FILL_W'(1);
    assign win_full = (new_fill == FILL_W'(MARKER_LEN));
    assign match    = win_full && (w_app == MARKER_WORD);
    assign key_byte = r_key[8*r_phase +: 8];

    always_comb begin
        n_count = r_count;
        if (!r_xor && match && (r_count != COUNT_MAX)) begin
            n_count = r_count + COUNT_WIDTH'(1);
        end
    end

    always_comb begin
        o_cmd              = '0;
        o_cmd.bytes        = w_app;
        o_cmd.last_end     = i_item.stream_end;
        o_cmd.strings_done = STR_W'(n_count);
        if (r_xor) begin
            o_cmd.bytes[0] = i_item.data_byte ^ key_byte;
            o_cmd.count    = FILL_W'(1);
        end else if (match) begin
            o_cmd.bytes[0] = CARET_CHAR;
            for (int i = 0; i < KEY_BYTES; i++) begin
                o_cmd.bytes[i+1] = i_item.fresh_key[8*i +: 8];
            end
            o_cmd.count = FILL_W'(MARKER_LEN);
        end else if (win_full && !i_item.stream_end) begin
            o_cmd.count = FILL_W'(1);
        end else if (i_item.stream_end) begin
            o_cmd.count = new_fill;
        end else begin
            o_cmd.count = '0;
        end
    end

    assign o_push = i_accept && (o_cmd.count != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_xor   <= 1'b0;
            r_key   <= '0;
            r_phase <= '0;
            r_count <= '0;
        end else if (i_accept) begin
            r_count <= n_count;
            if (r_xor) begin
                r_phase <= r_phase + PHASE_W'(1);
                if (i_item.data_byte == NUL_CHAR) begin
                    r_xor <= 1'b0;
                end
            end else if (match) begin
                r_fill  <= '0;
                r_xor   <= 1'b1;
                r_key   <= i_item.fresh_key;
                r_phase <= '0;
            end else if (win_full && !i_item.stream_end) begin
                r_fill <= FILL_W'(MARKER_LEN - 1);
            end else begin
                r_fill <= new_fill;
            end
            if (i_item.stream_end) begin
                r_fill  <= '0;
                r_xor   <= 1'b0;
                r_phase <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && !r_xor) begin
            if (win_full && !match && !i_item.stream_end) begin
                for (int i = 0; i < MARKER_LEN - 1; i++) begin
                    r_win[i] <= w_app[i+1];
                end
            end else begin
                r_win <= w_app;
            end
        end
    end

endmodule

>>> hw/rtl/mso_queue.sv
module mso_queue
    import mso_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_ready,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_ready = (r_cnt != QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

>>> hw/rtl/mso_back.sv
module mso_back
    import mso_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_valid,
    input  t_cmd      i_q_cmd,
    output logic      o_pop,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_item
);

    logic              r_busy;
    t_cmd              r_cur;
    logic [FILL_W-1:0] r_idx;
    logic              last;
    logic              fire;
    logic              done;

    assign last    = (r_idx == r_cur.count - FILL_W'(1));
    assign o_valid = r_busy;
    assign fire    = r_busy && i_ready;
    assign done    = fire && last;
    assign o_pop   = i_q_valid && (!r_busy || done);

    assign o_item.out_byte     = r_cur.bytes[r_idx];
    assign o_item.out_end      = r_cur.last_end && last;
    assign o_item.strings_done = r_cur.strings_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (done) begin
            r_busy <= 1'b0;
        end else if (fire) begin
            r_idx <= r_idx + FILL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_q_cmd;
        end
    end

endmodule
